@@ rtl/frt_pkg.sv @@
// Package: shared constants and types for the frequency range table.
package frt_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int FREQ_BITS_DEFAULT = 40;
   localparam int FIELD_FREQ_BITS = 40;
   localparam int SLOT_BITS = 5;

   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_FIND = 3'd2;
   localparam logic [2:0] OP_OVERLAP = 3'd3;
   localparam logic [2:0] OP_STEP = 3'd4;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_FULL = 3'd1;
   localparam logic [2:0] ST_NO_MATCH = 3'd2;
   localparam logic [2:0] ST_NO_CURRENT = 3'd3;
   localparam logic [2:0] ST_NONE_SEL = 3'd4;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request
      logic clear;      // empty table
      logic write;      // store request at fill count
      logic rd_en;      // read slot at rd_addr
      logic hold;       // keep current slot data as pending overlap match
   } frt_cmd_type;

endpackage

@@ rtl/frequency_range_table_top.sv @@
// Top level: frequency range table with command-style request and strobed results.
// Clear and insert accept no new request until their result has been shown; find and step
// scan one slot per cycle through the slot memory's single read port. Results
// appear on rsp_ ports for one cycle with rsp_valid and cannot be stalled;
// busy stays high until the final result has been shown.
module frequency_range_table_top #(
   parameter int TableDepth = frt_pkg::DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [2:0] req_op,
   input  logic [7:0] req_entry_id,
   input  logic [frt_pkg::FIELD_FREQ_BITS-1:0] req_range_start,
   input  logic [frt_pkg::FIELD_FREQ_BITS-1:0] req_range_stop,
   input  logic [7:0] req_range_kind,
   input  logic [frt_pkg::FIELD_FREQ_BITS-1:0] req_query_freq,
   input  logic [30:0] req_half_width,
   input  logic req_step_up,
   input  logic [7:0] req_current_id,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic rsp_found,
   output logic [frt_pkg::SLOT_BITS-1:0] rsp_slot_index,
   output logic [7:0] rsp_match_id,
   output logic [frt_pkg::FIELD_FREQ_BITS-1:0] rsp_match_start,
   output logic [frt_pkg::FIELD_FREQ_BITS-1:0] rsp_match_stop,
   output logic [7:0] rsp_match_kind,
   output logic rsp_last
);
   import frt_pkg::*;
   localparam int AddrBits = $clog2(TableDepth);
   localparam int FreqBits = FREQ_BITS_DEFAULT;

   frt_cmd_type cmd;
   logic [AddrBits-1:0] rd_addr, out_slot;
   logic [AddrBits:0] fill_count;
   logic contain_hit, overlap_hit, id_hit, kind_nz, out_found;
   logic [7:0] rd_id, rd_kind;
   logic [FIELD_FREQ_BITS-1:0] rd_start, rd_stop;

   frt_ctrl #(.TableDepth(TableDepth), .AddrBits(AddrBits)) u_ctrl (
      .clock, .reset, .start(start && !busy), .req_op, .req_step_up, .fill_count,
      .contain_hit, .overlap_hit, .id_hit, .kind_nz, .cmd, .rd_addr, .busy,
      .out_valid(rsp_valid), .out_status(rsp_status), .out_found, .out_slot,
      .out_last(rsp_last)
   );

   frt_datapath #(.TableDepth(TableDepth), .AddrBits(AddrBits))
   u_dp (
      .clock, .reset, .cmd, .rd_addr, .req_entry_id, .req_range_start,
      .req_range_stop, .req_range_kind, .req_query_freq, .req_half_width,
      .req_current_id, .fill_count, .contain_hit, .overlap_hit, .id_hit, .kind_nz,
      .rd_id, .rd_start, .rd_stop, .rd_kind
   );

   // match data comes from the last slot read; insert results use request fields
   logic ins_ff;
   logic [7:0] iid_ff, ikind_ff;
   logic [FIELD_FREQ_BITS-1:0] istart_ff, istop_ff;
   logic [FIELD_FREQ_BITS-1:0] fmask;
   logic [7:0] hid_ff, hkind_ff;
   logic [FIELD_FREQ_BITS-1:0] hstart_ff, hstop_ff;
   assign fmask = FIELD_FREQ_BITS'({FreqBits{1'b1}});

   always_ff @(posedge clock) begin
      if (reset) ins_ff <= 1'b0;
      else ins_ff <= start && !busy && req_op == OP_INSERT;
      iid_ff <= req_entry_id; ikind_ff <= req_range_kind;
      istart_ff <= req_range_start & fmask; istop_ff <= req_range_stop & fmask;
      hid_ff <= rd_id; hkind_ff <= rd_kind; hstart_ff <= rd_start; hstop_ff <= rd_stop;
   end

   // overlap results report the pending match, which is replaced on each new hit
   logic ovl_pend_ff;
   logic [7:0] pid_ff, pkind_ff, oid_ff, okind_ff;
   logic [FIELD_FREQ_BITS-1:0] pstart_ff, pstop_ff, ostart_ff, ostop_ff;
   always_ff @(posedge clock) begin
      if (reset) ovl_pend_ff <= 1'b0;
      else if (start && !busy) ovl_pend_ff <= (req_op == OP_OVERLAP);
      oid_ff <= pid_ff; okind_ff <= pkind_ff; ostart_ff <= pstart_ff; ostop_ff <= pstop_ff;
      if (cmd.hold) begin
         pid_ff <= rd_id; pkind_ff <= rd_kind; pstart_ff <= rd_start; pstop_ff <= rd_stop;
      end
   end

   logic [7:0] sid, skind;
   logic [FIELD_FREQ_BITS-1:0] sstart, sstop;
   always_comb begin
      if (ins_ff) begin
         sid = iid_ff; skind = ikind_ff; sstart = istart_ff; sstop = istop_ff;
      end else if (ovl_pend_ff) begin
         sid = oid_ff; skind = okind_ff; sstart = ostart_ff; sstop = ostop_ff;
      end else begin
         sid = hid_ff; skind = hkind_ff; sstart = hstart_ff; sstop = hstop_ff;
      end
   end

   assign rsp_found = out_found;
   assign rsp_slot_index = out_found ? SLOT_BITS'(out_slot) : '0;
   assign rsp_match_id = out_found ? sid : '0;
   assign rsp_match_start = out_found ? sstart : '0;
   assign rsp_match_stop = out_found ? sstop : '0;
   assign rsp_match_kind = out_found ? skind : '0;
endmodule

@@ rtl/frt_datapath.sv @@
// Datapath: slot memory, fill count, request registers and match compares.
module frt_datapath #(
   parameter int TableDepth = frt_pkg::DEPTH_DEFAULT,
   parameter int AddrBits = $clog2(TableDepth)
) (
   input  logic clock,
   input  logic reset,
   input  frt_pkg::frt_cmd_type cmd,
   input  logic [AddrBits-1:0] rd_addr,
   input  logic [7:0] req_entry_id,
   input  logic [frt_pkg::FIELD_FREQ_BITS-1:0] req_range_start,
   input  logic [frt_pkg::FIELD_FREQ_BITS-1:0] req_range_stop,
   input  logic [7:0] req_range_kind,
   input  logic [frt_pkg::FIELD_FREQ_BITS-1:0] req_query_freq,
   input  logic [30:0] req_half_width,
   input  logic [7:0] req_current_id,
   output logic [AddrBits:0] fill_count,
   output logic contain_hit,
   output logic overlap_hit,
   output logic id_hit,
   output logic kind_nz,
   output logic [7:0] rd_id,
   output logic [frt_pkg::FIELD_FREQ_BITS-1:0] rd_start,
   output logic [frt_pkg::FIELD_FREQ_BITS-1:0] rd_stop,
   output logic [7:0] rd_kind
);
   import frt_pkg::*;

   localparam int FreqBits = FREQ_BITS_DEFAULT;
   localparam logic [FreqBits:0] FMAX = {1'b0, {FreqBits{1'b1}}};

   logic [7:0]          mem_id [TableDepth];
   logic [FreqBits-1:0] mem_start [TableDepth];
   logic [FreqBits-1:0] mem_stop [TableDepth];
   logic [7:0]          mem_kind [TableDepth];

   logic [AddrBits:0] fill_ff, fill_in;
   logic [7:0] id_q_ff;
   logic [FreqBits-1:0] left_ff, right_ff, freq_ff;
   logic [FreqBits-1:0] s_ff, e_ff;
   logic [7:0] rid_ff, rkind_ff;
   logic [FreqBits-1:0] f_cut, lw, rw;
   logic [FreqBits:0] fsum;
   logic [FreqBits:0] hw_ext;

   assign f_cut = req_query_freq[FreqBits-1:0];
   assign hw_ext = (FreqBits + 1)'(req_half_width);
   assign fsum = {1'b0, f_cut} + hw_ext;
   assign lw = ({1'b0, f_cut} > hw_ext) ? f_cut - hw_ext[FreqBits-1:0] : '0;
   assign rw = (fsum > FMAX) ? FMAX[FreqBits-1:0] : fsum[FreqBits-1:0];

   always_comb begin
      fill_in = fill_ff;
      if (cmd.clear) fill_in = '0;
      else if (cmd.write) fill_in = fill_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) fill_ff <= '0;
      else fill_ff <= fill_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem_id[fill_ff[AddrBits-1:0]] <= req_entry_id;
         mem_start[fill_ff[AddrBits-1:0]] <= req_range_start[FreqBits-1:0];
         mem_stop[fill_ff[AddrBits-1:0]] <= req_range_stop[FreqBits-1:0];
         mem_kind[fill_ff[AddrBits-1:0]] <= req_range_kind;
      end
      if (cmd.rd_en) begin
         rid_ff <= mem_id[rd_addr];
         s_ff <= mem_start[rd_addr];
         e_ff <= mem_stop[rd_addr];
         rkind_ff <= mem_kind[rd_addr];
      end
      if (cmd.load) begin
         id_q_ff <= req_current_id;
         freq_ff <= f_cut;
         left_ff <= lw;
         right_ff <= rw;
      end
   end

   assign fill_count = fill_ff;
   assign contain_hit = (freq_ff >= s_ff) && (freq_ff <= e_ff);
   assign overlap_hit = (e_ff >= left_ff && e_ff <= right_ff) ||
                        (s_ff >= left_ff && s_ff <= right_ff) ||
                        (s_ff <= left_ff && e_ff >= right_ff);
   assign id_hit = (rid_ff == id_q_ff);
   assign kind_nz = (rkind_ff != 8'd0);
   assign rd_id = rid_ff;
   assign rd_start = FIELD_FREQ_BITS'(s_ff);
   assign rd_stop = FIELD_FREQ_BITS'(e_ff);
   assign rd_kind = rkind_ff;
endmodule

@@ rtl/frt_ctrl.sv @@
// Controller: sequences slot scans and emits result strobes.
module frt_ctrl #(
   parameter int TableDepth = frt_pkg::DEPTH_DEFAULT,
   parameter int AddrBits = $clog2(TableDepth)
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [2:0] req_op,
   input  logic req_step_up,
   input  logic [AddrBits:0] fill_count,
   input  logic contain_hit,
   input  logic overlap_hit,
   input  logic id_hit,
   input  logic kind_nz,
   output frt_pkg::frt_cmd_type cmd,
   output logic [AddrBits-1:0] rd_addr,
   output logic busy,
   output logic out_valid,
   output logic [2:0] out_status,
   output logic out_found,
   output logic [AddrBits-1:0] out_slot,
   output logic out_last
);
   import frt_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FIND = 3'd1;
   localparam logic [2:0] S_OVL = 3'd2;
   localparam logic [2:0] S_LOC = 3'd3;
   localparam logic [2:0] S_STEP = 3'd4;
   localparam logic [2:0] S_FLUSH = 3'd5;
   localparam logic [AddrBits-1:0] TOP = AddrBits'(TableDepth - 1);
   localparam logic [AddrBits:0] DEPTH_C = (AddrBits + 1)'(TableDepth);

   logic [2:0] state_ff, state_in;
   logic [AddrBits-1:0] addr_ff, addr_in, cur_ff, cur_in;
   logic [AddrBits:0] cnt_ff, cnt_in;
   logic dir_ff, dir_in, chk_ff, chk_in;
   logic pend_ff, pend_in, any_ff, any_in;
   logic [AddrBits-1:0] pslot_ff, pslot_in, chk_addr_ff;
   logic ov_ff, ov_in;
   logic [2:0] st_ff, st_in;
   logic fnd_ff, fnd_in, lst_ff, lst_in;
   logic [AddrBits-1:0] slot_ff, slot_in;
   logic [AddrBits-1:0] nxt;

   assign nxt = dir_ff ? ((cur_ff == TOP) ? '0 : cur_ff + 1'b1)
                       : ((cur_ff == '0) ? TOP : cur_ff - 1'b1);

   always_comb begin
      state_in = state_ff; addr_in = addr_ff; cur_in = cur_ff; cnt_in = cnt_ff;
      dir_in = dir_ff; chk_in = 1'b0; pend_in = pend_ff; any_in = any_ff;
      pslot_in = pslot_ff; ov_in = 1'b0; st_in = st_ff; fnd_in = 1'b0;
      lst_in = 1'b0; slot_in = slot_ff;
      cmd = '0;
      rd_addr = addr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               dir_in = req_step_up;
               pend_in = 1'b0; any_in = 1'b0;
               unique case (req_op)
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     ov_in = 1'b1; st_in = ST_OK; lst_in = 1'b1;
                  end
                  OP_INSERT: begin
                     ov_in = 1'b1; lst_in = 1'b1;
                     if (fill_count == DEPTH_C) st_in = ST_FULL;
                     else begin
                        cmd.write = 1'b1; st_in = ST_OK; fnd_in = 1'b1;
                        slot_in = fill_count[AddrBits-1:0];
                     end
                  end
                  OP_FIND: begin
                     addr_in = '0; cnt_in = '0; state_in = S_FIND;
                  end
                  OP_OVERLAP: begin
                     addr_in = fill_count[AddrBits-1:0] - 1'b1;
                     cnt_in = fill_count; state_in = S_OVL;
                  end
                  OP_STEP: begin
                     addr_in = '0; cnt_in = '0; state_in = S_LOC;
                  end
                  default: ;
               endcase
            end
         end
         S_FIND: begin
            // issue read at addr_ff, check prior read
            if (chk_ff && contain_hit) begin
               ov_in = 1'b1; st_in = ST_OK; fnd_in = 1'b1; lst_in = 1'b1;
               slot_in = chk_addr_ff; state_in = S_IDLE;
            end else if (cnt_ff == fill_count) begin
               if (!chk_ff || !contain_hit) begin
                  ov_in = 1'b1; st_in = ST_NO_MATCH; lst_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.rd_en = 1'b1; chk_in = 1'b1;
               addr_in = addr_ff + 1'b1; cnt_in = cnt_ff + 1'b1;
            end
         end
         S_OVL: begin
            // hold a match pending so the last one can carry the last mark
            if (chk_ff && overlap_hit) begin
               if (pend_ff) begin
                  ov_in = 1'b1; st_in = ST_OK; fnd_in = 1'b1; slot_in = pslot_ff;
               end
               cmd.hold = 1'b1;
               pend_in = 1'b1; pslot_in = chk_addr_ff; any_in = 1'b1;
            end
            if (cnt_ff == '0) begin
               state_in = S_FLUSH;
            end else begin
               cmd.rd_en = 1'b1; chk_in = 1'b1;
               addr_in = addr_ff - 1'b1; cnt_in = cnt_ff - 1'b1;
            end
         end
         S_FLUSH: begin
            ov_in = 1'b1; lst_in = 1'b1; state_in = S_IDLE;
            if (any_ff) begin
               st_in = ST_OK; fnd_in = 1'b1; slot_in = pslot_ff;
            end else st_in = ST_NO_MATCH;
         end
         S_LOC: begin
            if (chk_ff && id_hit) begin
               cur_in = chk_addr_ff; cnt_in = '0; state_in = S_STEP;
            end else if (cnt_ff == fill_count) begin
               ov_in = 1'b1; st_in = ST_NO_CURRENT; lst_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.rd_en = 1'b1; chk_in = 1'b1;
               addr_in = addr_ff + 1'b1; cnt_in = cnt_ff + 1'b1;
            end
         end
         S_STEP: begin
            // chk_ff: previous slot read is valid for test
            if (chk_ff && kind_nz) begin
               ov_in = 1'b1; st_in = ST_OK; fnd_in = 1'b1; lst_in = 1'b1;
               slot_in = chk_addr_ff; state_in = S_IDLE;
            end else if (cnt_ff == DEPTH_C) begin
               ov_in = 1'b1; st_in = ST_NONE_SEL; lst_in = 1'b1; state_in = S_IDLE;
            end else begin
               cur_in = nxt; cnt_in = cnt_ff + 1'b1;
               rd_addr = nxt;
               if ((AddrBits + 1)'(nxt) < fill_count) begin
                  cmd.rd_en = 1'b1; chk_in = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         chk_ff <= 1'b0;
         ov_ff <= 1'b0;
         pend_ff <= 1'b0;
         any_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chk_ff <= chk_in;
         ov_ff <= ov_in;
         pend_ff <= pend_in;
         any_ff <= any_in;
      end
      addr_ff <= addr_in; cur_ff <= cur_in; cnt_ff <= cnt_in; dir_ff <= dir_in;
      pslot_ff <= pslot_in; st_ff <= st_in; fnd_ff <= fnd_in; lst_ff <= lst_in;
      slot_ff <= slot_in;
      chk_addr_ff <= rd_addr;
   end

   assign busy = (state_ff != S_IDLE) || ov_ff;
   assign out_valid = ov_ff;
   assign out_status = st_ff;
   assign out_found = fnd_ff;
   assign out_slot = slot_ff;
   assign out_last = lst_ff;
endmodule

@@ rtl/frt_checker.sv @@
// Checker: port-level properties of the frequency range table.
module frt_props (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_found,
   input logic rsp_last,
   input logic [2:0] rsp_status,
   input logic [4:0] rsp_slot_index
);
   import frt_pkg::*;

   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result without busy");
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ST_OK) else $error("found with bad status");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last) else $error("error not last");
   a_nofound_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_slot_index == 5'd0) else $error("slot without match");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid) else $error("result after last");
endmodule

bind frequency_range_table_top frt_props u_frt_props (
   .clock, .reset, .busy, .rsp_valid, .rsp_found, .rsp_last, .rsp_status,
   .rsp_slot_index
);
